[rtl/assert_macros.svh]
// Assertion macros shared by the inode cache RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst_n is low.
`define AST_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst_n is low.
`define AST_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/icgp_pkg.sv]
// Shared types and constants of the inode cache get/put unit.
package icgp_pkg;

    localparam int DEV_W    = 8;
    localparam int INO_W    = 24;
    localparam int REFS_W   = 16;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 3;
    localparam int BLK_W    = 25;
    localparam int OFF_W    = 3;
    localparam int START_W  = 24;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
    localparam logic [STATUS_W-1:0] ST_LOAD      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HELD      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_CLEAN     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_WRITEBACK = 3'd5;
    localparam logic [STATUS_W-1:0] ST_NOTHELD   = 3'd6;

    localparam logic [REFS_W-1:0] REFS_MAX = '1;

    // One entry of the in-core table.
    typedef struct packed {
        logic [DEV_W-1:0]  dev;
        logic [INO_W-1:0]  ino;
        logic [REFS_W-1:0] refs;
        logic              dirty;
    } entry_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_req;
        logic cnt_clear;
        logic cnt_step;
        logic clear_wr;
        logic rd_scan;
        logic rd_slot;
        logic get_decide;
        logic put_eval;
        logic div_start;
        logic div_step;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic cnt_last;
        logic need_div;
        logic div_last;
    } sts_t;

endpackage

[rtl/inode_cache_get_put_unit.sv]
// Top level of the reference-counted in-core inode table (get/put unit).
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-----------------------------------------------
//  cfg     | cfg_we               | cfg_wdata (inode table start block)
//  in      | in_valid / in_ready  | req_type, dev, ino, slot, set_dirty
//  out     | out_valid / out_ready| entry_slot, status, disk_block, inode_offset,
//          |                      | ref_count
//
//  A get scans the table, reading one table entry per cycle through the single memory
//  read port, then decides, and runs the reciprocal-multiply block divider when an
//  entry is allocated. A put reads and evaluates its slot, and runs the same divider
//  when it writes back. After reset a clearing pass writes every entry to zero,
//  during which in_ready stays low.
//  One request is in flight at a time; a finished result waits in the output
//  register while the next beat is accepted, and a stalled out_ready holds only
//  the following result.
module inode_cache_get_put_unit
#(
    parameter int TABLE_ENTRIES    = 64,
    parameter int INODES_PER_BLOCK = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [icgp_pkg::START_W-1:0]    cfg_wdata,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic                            req_type,
    input  logic [icgp_pkg::DEV_W-1:0]      dev,
    input  logic [icgp_pkg::INO_W-1:0]      ino,
    input  logic [icgp_pkg::SLOT_W-1:0]     slot,
    input  logic                            set_dirty,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [icgp_pkg::SLOT_W-1:0]     entry_slot,
    output logic [icgp_pkg::STATUS_W-1:0]   status,
    output logic [icgp_pkg::BLK_W-1:0]      disk_block,
    output logic [icgp_pkg::OFF_W-1:0]      inode_offset,
    output logic [icgp_pkg::REFS_W-1:0]     ref_count
);

    // The controller sequences the clearing pass, the scan, the decision step,
    // the divider and the output load; the datapath holds the table and the data registers.
    icgp_pkg::cmd_t cmd;
    icgp_pkg::sts_t sts;

    icgp_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .req_type  (req_type),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // The datapath owns the entry memory, the scan trackers, the block divider
    // and the output register that holds a result beat until it is taken.
    icgp_dpath
    #(
        .TABLE_ENTRIES    (TABLE_ENTRIES),
        .INODES_PER_BLOCK (INODES_PER_BLOCK)
    )
    u_dpath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .req_type     (req_type),
        .dev          (dev),
        .ino          (ino),
        .slot         (slot),
        .set_dirty    (set_dirty),
        .cmd          (cmd),
        .sts          (sts),
        .entry_slot   (entry_slot),
        .status       (status),
        .disk_block   (disk_block),
        .inode_offset (inode_offset),
        .ref_count    (ref_count)
    );

endmodule

[rtl/icgp_ctrl.sv]
// Controller state machine of the inode cache get/put unit.
`include "assert_macros.svh"

module icgp_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic            req_type,
    output logic            out_valid,
    input  logic            out_ready,
    output icgp_pkg::cmd_t  cmd,
    input  icgp_pkg::sts_t  sts
);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PUT_READ,
        S_PUT_EVAL,
        S_SCAN,
        S_DRAIN,
        S_GET_DECIDE,
        S_DIVIDE,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        in_ready       = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        case (state_reg)
            S_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                cmd.cnt_step = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req  = 1'b1;
                    cmd.cnt_clear = 1'b1;
                    state_next    = req_type ? S_PUT_READ : S_SCAN;
                end
            end
            S_PUT_READ:
            begin
                cmd.rd_slot = 1'b1;
                state_next  = S_PUT_EVAL;
            end
            S_PUT_EVAL:
            begin
                cmd.put_eval  = 1'b1;
                cmd.div_start = sts.need_div;
                state_next    = sts.need_div ? S_DIVIDE : S_RESULT;
            end
            S_SCAN:
            begin
                cmd.rd_scan  = 1'b1;
                cmd.cnt_step = 1'b1;
                if (sts.cnt_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_GET_DECIDE;
            end
            S_GET_DECIDE:
            begin
                cmd.get_decide = 1'b1;
                cmd.div_start  = sts.need_div;
                state_next     = sts.need_div ? S_DIVIDE : S_RESULT;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `AST_NEXT(a_accept_starts, in_valid && in_ready, state_reg == S_SCAN || state_reg == S_PUT_READ, "accepted beat did not start a get or put")
    `AST_IMPL(a_out_from_result, $rose(out_valid_reg), $past(state_reg == S_RESULT), "result beat raised outside the result state")

endmodule

[rtl/icgp_dpath.sv]
// Datapath of the inode cache get/put unit: entry table, scan, divider, result.
`include "assert_macros.svh"

module icgp_dpath
#(
    parameter int TABLE_ENTRIES    = 64,
    parameter int INODES_PER_BLOCK = 8
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [icgp_pkg::START_W-1:0]    cfg_wdata,
    input  logic                            req_type,
    input  logic [icgp_pkg::DEV_W-1:0]      dev,
    input  logic [icgp_pkg::INO_W-1:0]      ino,
    input  logic [icgp_pkg::SLOT_W-1:0]     slot,
    input  logic                            set_dirty,
    input  icgp_pkg::cmd_t                  cmd,
    output icgp_pkg::sts_t                  sts,
    output logic [icgp_pkg::SLOT_W-1:0]     entry_slot,
    output logic [icgp_pkg::STATUS_W-1:0]   status,
    output logic [icgp_pkg::BLK_W-1:0]      disk_block,
    output logic [icgp_pkg::OFF_W-1:0]      inode_offset,
    output logic [icgp_pkg::REFS_W-1:0]     ref_count
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);
    localparam int INO_W = icgp_pkg::INO_W;
    localparam logic [INO_W-1:0] DIV_D = INO_W'(INODES_PER_BLOCK);
    // Truncated reciprocal; the estimate it gives is at most one below the quotient.
    localparam logic [INO_W:0] DIV_RECIP =
        (INO_W + 1)'((longint'(1) << INO_W) / longint'(INODES_PER_BLOCK));
    localparam logic [1:0] DIV_LAST = 2'd2;

    function automatic logic [icgp_pkg::SLOT_W-1:0] idx_to_slot(input logic [IDX_W-1:0] idx);
        logic [15:0] w;
        w = 16'(idx);
        return w[icgp_pkg::SLOT_W-1:0];
    endfunction

    // Configuration and captured request.
    logic [icgp_pkg::START_W-1:0] start_reg;
    logic                         req_type_reg;
    logic [icgp_pkg::DEV_W-1:0]   dev_reg;
    logic [icgp_pkg::INO_W-1:0]   ino_reg;
    logic [icgp_pkg::SLOT_W-1:0]  slot_reg;
    logic                         set_dirty_reg;

    // Table memory and its read stage.
    icgp_pkg::entry_t mem [TABLE_ENTRIES];
    icgp_pkg::entry_t rd_data_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    logic             rd_vld_reg;
    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] rd_addr;
    logic             rd_en;
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    icgp_pkg::entry_t wr_data;

    // Scan trackers.
    logic             hit_found_reg;
    logic [IDX_W-1:0] hit_idx_reg;
    icgp_pkg::entry_t hit_ent_reg;
    logic             free_found_reg;
    logic [IDX_W-1:0] free_idx_reg;

    // Divider.
    logic [INO_W-1:0]             div_x_reg;
    logic [INO_W-1:0]             div_qe_reg;
    logic [INO_W-1:0]             div_rest_reg;
    logic [INO_W-1:0]             div_q_reg;
    logic [icgp_pkg::OFF_W-1:0]   div_rem_reg;
    logic [1:0]                   div_cnt_reg;
    logic [2*INO_W-1:0]           div_prod;
    logic [INO_W-1:0]             div_back;
    logic                         div_ge;
    logic [INO_W-1:0]             div_rem_full;
    logic [INO_W-1:0]             div_src;

    // Pending result and output registers.
    logic [icgp_pkg::SLOT_W-1:0]   res_slot_reg;
    logic [icgp_pkg::STATUS_W-1:0] res_status_reg;
    logic [icgp_pkg::REFS_W-1:0]   res_refs_reg;
    logic                          res_loc_reg;
    logic [icgp_pkg::SLOT_W-1:0]   entry_slot_reg;
    logic [icgp_pkg::STATUS_W-1:0] status_reg;
    logic [icgp_pkg::BLK_W-1:0]    disk_block_reg;
    logic [icgp_pkg::OFF_W-1:0]    inode_offset_reg;
    logic [icgp_pkg::REFS_W-1:0]   ref_count_reg;

    logic [15:0]                 slot_wide;
    logic [IDX_W-1:0]            slot_idx;
    logic                        slot_ok;
    logic                        is_match;
    logic                        is_free;
    logic                        get_alloc;
    logic                        put_held;
    logic                        dirty_any;
    logic                        put_wb;
    logic [icgp_pkg::REFS_W-1:0] refs_dec;
    logic [icgp_pkg::REFS_W-1:0] hit_refs;
    logic [icgp_pkg::BLK_W-1:0]  blk_sum;

    assign slot_wide = {10'b0, slot_reg};
    assign slot_idx  = slot_wide[IDX_W-1:0];
    assign slot_ok   = ({5'b0, slot_reg} < 11'(TABLE_ENTRIES));

    assign is_match = rd_vld_reg && (rd_data_reg.ino != '0) &&
                      (rd_data_reg.dev == dev_reg) && (rd_data_reg.ino == ino_reg);
    assign is_free  = rd_vld_reg && (rd_data_reg.refs == '0);

    assign get_alloc = !hit_found_reg && free_found_reg;
    assign hit_refs  = (hit_ent_reg.refs == icgp_pkg::REFS_MAX) ? icgp_pkg::REFS_MAX
                                                                : hit_ent_reg.refs + 16'd1;

    assign put_held  = slot_ok && (rd_data_reg.refs != '0);
    assign refs_dec  = rd_data_reg.refs - 16'd1;
    assign dirty_any = rd_data_reg.dirty | set_dirty_reg;
    assign put_wb    = put_held && (refs_dec == '0) && dirty_any;

    assign sts.cnt_last = (cnt_reg == LAST_IDX);
    assign sts.need_div = req_type_reg ? put_wb : get_alloc;
    assign sts.div_last = (div_cnt_reg == DIV_LAST);

    assign rd_en   = cmd.rd_scan | cmd.rd_slot;
    assign rd_addr = cmd.rd_slot ? slot_idx : cnt_reg;

    // One table write per cycle: clearing pass, get update or put update.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_idx  = cnt_reg;
        wr_data = '0;
        if (cmd.clear_wr)
        begin
            wr_en = 1'b1;
        end
        else if (cmd.get_decide && hit_found_reg)
        begin
            wr_en        = 1'b1;
            wr_idx       = hit_idx_reg;
            wr_data      = hit_ent_reg;
            wr_data.refs = hit_refs;
        end
        else if (cmd.get_decide && get_alloc)
        begin
            wr_en         = 1'b1;
            wr_idx        = free_idx_reg;
            wr_data.dev   = dev_reg;
            wr_data.ino   = ino_reg;
            wr_data.refs  = 16'd1;
            wr_data.dirty = 1'b0;
        end
        else if (cmd.put_eval && put_held)
        begin
            wr_en         = 1'b1;
            wr_idx        = slot_idx;
            wr_data.dev   = rd_data_reg.dev;
            wr_data.ino   = rd_data_reg.ino;
            wr_data.refs  = refs_dec;
            wr_data.dirty = (refs_dec != '0) && dirty_any;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
            rd_idx_reg  <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg      <= '0;
            cnt_reg        <= '0;
            rd_vld_reg     <= 1'b0;
            hit_found_reg  <= 1'b0;
            free_found_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                start_reg <= cfg_wdata;
            end
            if (cmd.cnt_clear)
            begin
                cnt_reg <= '0;
            end
            else if (cmd.cnt_step)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            rd_vld_reg <= cmd.rd_scan;
            if (cmd.load_req)
            begin
                hit_found_reg  <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else
            begin
                if (is_match && !hit_found_reg)
                begin
                    hit_found_reg <= 1'b1;
                end
                if (is_free && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_type_reg  <= req_type;
            dev_reg       <= dev;
            ino_reg       <= ino;
            slot_reg      <= slot;
            set_dirty_reg <= set_dirty;
        end
        if (is_match && !hit_found_reg)
        begin
            hit_idx_reg <= rd_idx_reg;
            hit_ent_reg <= rd_data_reg;
        end
        if (is_free && !free_found_reg)
        begin
            free_idx_reg <= rd_idx_reg;
        end
    end

    // Division of (ino - 1) by the inodes-per-block constant in three steps:
    // a reciprocal multiply for the quotient estimate, the remainder of that
    // estimate, then one correction when the remainder reaches the divisor.
    assign div_src      = req_type_reg ? rd_data_reg.ino : ino_reg;
    assign div_prod     = (2*INO_W)'(div_x_reg) * (2*INO_W)'(DIV_RECIP);
    assign div_back     = div_qe_reg * DIV_D;
    assign div_ge       = (div_rest_reg >= DIV_D);
    assign div_rem_full = div_ge ? (div_rest_reg - DIV_D) : div_rest_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            div_x_reg   <= div_src - 24'd1;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            div_qe_reg   <= div_prod[2*INO_W-1:INO_W];
            div_rest_reg <= div_x_reg - div_back;
            div_q_reg    <= div_qe_reg + INO_W'(div_ge);
            div_rem_reg  <= div_rem_full[icgp_pkg::OFF_W-1:0];
            div_cnt_reg  <= div_cnt_reg + 2'd1;
        end
    end

    // Result of the decision step; block and offset come from the divider later.
    always_ff @(posedge clk)
    begin
        if (cmd.get_decide)
        begin
            if (hit_found_reg)
            begin
                res_slot_reg   <= idx_to_slot(hit_idx_reg);
                res_status_reg <= icgp_pkg::ST_HIT;
                res_refs_reg   <= hit_refs;
                res_loc_reg    <= 1'b0;
            end
            else if (free_found_reg)
            begin
                res_slot_reg   <= idx_to_slot(free_idx_reg);
                res_status_reg <= icgp_pkg::ST_LOAD;
                res_refs_reg   <= 16'd1;
                res_loc_reg    <= 1'b1;
            end
            else
            begin
                res_slot_reg   <= '0;
                res_status_reg <= icgp_pkg::ST_FULL;
                res_refs_reg   <= '0;
                res_loc_reg    <= 1'b0;
            end
        end
        else if (cmd.put_eval)
        begin
            res_slot_reg <= slot_reg;
            if (!put_held)
            begin
                res_status_reg <= icgp_pkg::ST_NOTHELD;
                res_refs_reg   <= '0;
                res_loc_reg    <= 1'b0;
            end
            else if (refs_dec != '0)
            begin
                res_status_reg <= icgp_pkg::ST_HELD;
                res_refs_reg   <= refs_dec;
                res_loc_reg    <= 1'b0;
            end
            else if (put_wb)
            begin
                res_status_reg <= icgp_pkg::ST_WRITEBACK;
                res_refs_reg   <= '0;
                res_loc_reg    <= 1'b1;
            end
            else
            begin
                res_status_reg <= icgp_pkg::ST_CLEAN;
                res_refs_reg   <= '0;
                res_loc_reg    <= 1'b0;
            end
        end
    end

    assign blk_sum = {1'b0, div_q_reg} + {1'b0, start_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            entry_slot_reg   <= res_slot_reg;
            status_reg       <= res_status_reg;
            ref_count_reg    <= res_refs_reg;
            disk_block_reg   <= res_loc_reg ? blk_sum : '0;
            inode_offset_reg <= res_loc_reg ? div_rem_reg : '0;
        end
    end

    assign entry_slot   = entry_slot_reg;
    assign status       = status_reg;
    assign disk_block   = disk_block_reg;
    assign inode_offset = inode_offset_reg;
    assign ref_count    = ref_count_reg;

    `AST_IMPL(a_wb_last_ref, cmd.put_eval && sts.need_div, rd_data_reg.refs == 16'd1, "early wb")
    `AST_IMPL(a_scan_drained, cmd.get_decide, !rd_vld_reg, "get decided before the scan drained")

endmodule
